### src/sorted_table_insert_assert.svh
// Assertion macros for the sorted table.
`ifndef SORTED_TABLE_INSERT_ASSERT_SVH
`define SORTED_TABLE_INSERT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sti_pkg.sv
`timescale 1ns / 1ps

package sti_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int READ_N    = 1 << INDEX_W;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_READ   = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Per-cell control broadcast from the top level.
    typedef struct packed {
        logic ins;      // insert this cycle
        logic valid;    // cell holds a stored entry
        logic at_fill;  // first empty cell
    } cell_ctrl_t;

endpackage

### src/sti_cell.sv
`timescale 1ns / 1ps

module sti_cell (
    input  logic                              clk,
    input  sti_pkg::cell_ctrl_t               ctrl,
    input  logic signed [sti_pkg::DATA_W-1:0] value,
    input  logic signed [sti_pkg::DATA_W-1:0] left_data,
    input  logic                              left_gt,
    output logic signed [sti_pkg::DATA_W-1:0] data,
    output logic                              gt
);
    import sti_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Entry sits above the new value: it moves up one place.
    assign gt = ctrl.valid && (data_reg > value);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            priority if (left_gt)
                data_next = left_data;
            else if (gt || ctrl.at_fill)
                data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### src/sorted_table_insert.sv
`timescale 1ns / 1ps
// Sorted table: keeps up to DEPTH signed 32-bit words in ascending order.
// Request channel (req_valid/req_stall) carries func, value and index:
//   insert places value after every entry <= value, shifting larger ones up;
//   read returns the entry at index; clear empties the table.
// Response channel (rsp_valid/rsp_stall) carries status, data and count,
// one response word per request word.
// Storage is a row of DEPTH cells. On insert every cell compares its entry
// with the broadcast value and either keeps it, takes its left neighbor's
// entry, or takes the new value, so all cells update together.
// Response valid rises in the cycle after a request is accepted.
// Throughput: one request per cycle; the response register is the only
// stage, and a request is taken whenever it is empty or being drained.
// Receiver stall: while rsp_stall holds a pending response, req_stall is
// raised and the table state does not change.
// Reset clears the entry count and the response valid; cell contents stay
// undefined until written and are never read at or above the count.
module sorted_table_insert #(
    parameter int DEPTH = sti_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [1:0]                         func,
    input  logic signed [sti_pkg::DATA_W-1:0]  value,
    input  logic [sti_pkg::INDEX_W-1:0]        index,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [1:0]                         status,
    output logic signed [sti_pkg::DATA_W-1:0]  data,
    output logic [sti_pkg::COUNT_W-1:0]        count
);
    import sti_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic                     acc;
    func_t                    fn;
    logic                     full;
    logic                     in_range;

    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;

    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;

    cell_ctrl_t               ctrl   [DEPTH];
    logic signed [DATA_W-1:0] cell_q [DEPTH];
    logic                     cell_gt[DEPTH-1];
    logic signed [DATA_W-1:0] rd_q   [READ_N];

    // Take a new word unless a response is stuck at the output.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign acc       = req_valid && !req_stall;
    assign fn        = func_t'(func);
    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign in_range  = (32'(index) < 32'(fill_reg));

    // ---- cell row ----
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign ctrl[i].ins     = acc && (fn == FN_INSERT) && !full;
        assign ctrl[i].valid   = (32'(i) < 32'(fill_reg));
        assign ctrl[i].at_fill = (32'(i) == 32'(fill_reg));

        if (i == 0)
        begin : g_first
            sti_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[i]),
                .value     (value),
                .left_data ('0),
                .left_gt   (1'b0),
                .data      (cell_q[i]),
                .gt        (cell_gt[i])
            );
        end
        else if (i == DEPTH - 1)
        begin : g_last
            // Top cell never hands its entry on.
            sti_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[i]),
                .value     (value),
                .left_data (cell_q[i-1]),
                .left_gt   (cell_gt[i-1]),
                .data      (cell_q[i]),
                .gt        ()
            );
        end
        else
        begin : g_mid
            sti_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[i]),
                .value     (value),
                .left_data (cell_q[i-1]),
                .left_gt   (cell_gt[i-1]),
                .data      (cell_q[i]),
                .gt        (cell_gt[i])
            );
        end
    end

    // Read port covers only the positions the index field can name.
    for (genvar j = 0; j < READ_N; j++)
    begin : g_rd
        if (j < DEPTH)
        begin : g_hit
            assign rd_q[j] = cell_q[j];
        end
        else
        begin : g_miss
            assign rd_q[j] = '0;
        end
    end

    // ---- request decode ----
    always_comb
    begin
        fill_next   = fill_reg;
        status_next = ST_OK;
        data_next   = '0;
        unique case (fn)
            FN_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    fill_next = fill_reg + FILL_W'(1);
            end
            FN_READ:
            begin
                if (in_range)
                    data_next = rd_q[index];
                else
                    status_next = ST_RANGE;
            end
            FN_CLEAR:
                fill_next = '0;
            default:
                fill_next = fill_reg;
        endcase
        count_next = COUNT_W'(fill_next);
    end

    always_comb
    begin
        if (acc)
            rsp_valid_next = 1'b1;
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (acc)
                fill_reg <= fill_next;
        end
    end

    // Response payload: loaded only on accept, holds while stalled.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            count_reg  <= count_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign count     = count_reg;

    // ---- checks ----
`include "sorted_table_insert_assert.svh"

    `STI_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(DEPTH), "fill exceeds DEPTH")
    `STI_ASSERT_NOW(a_full_count, rsp_valid_reg && (status_reg == ST_FULL), count_reg == COUNT_W'(DEPTH), "full status with table not full")
    `STI_ASSERT_NEXT(a_clear_empties, acc && (fn == FN_CLEAR), fill_reg == '0, "clear left entries")
    `STI_ASSERT_NOW(a_err_zero_data, rsp_valid_reg && (status_reg != ST_OK), data_reg == '0, "error response with nonzero data")

endmodule

### tb/sv/sorted_table_checker.sv
`timescale 1ns / 1ps

module sorted_table_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_stall,
    input  logic [1:0]                         func,
    input  logic signed [sti_pkg::DATA_W-1:0]  value,
    input  logic [sti_pkg::INDEX_W-1:0]        index,
    input  logic                               rsp_valid,
    input  logic                               rsp_stall,
    input  logic [1:0]                         status,
    input  logic signed [sti_pkg::DATA_W-1:0]  data,
    input  logic [sti_pkg::COUNT_W-1:0]        count,
    output int                                 mismatches,
    output int                                 outstanding
);
    import sti_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    data;
        logic [COUNT_W-1:0]   count;
    } reply_t;

    reply_t                   replies_due[$];
    reply_t                   due;
    logic signed [DATA_W-1:0] shadow [DEPTH];
    int unsigned              held;
    int                       errs;
    int                       rsp_words;

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: response word %0d, %s expected %0h, got %0h",
                 $time, rsp_words, field, want, got);
        errs++;
    endtask

    // Applies one request word to the shadow table, returns the reply it owes.
    function automatic reply_t apply_request(func_t fn, logic signed [DATA_W-1:0] v,
                                             logic [INDEX_W-1:0] idx);
        reply_t r;
        int     pos;
        int     k;
        r.status = ST_OK;
        r.data   = '0;
        case (fn)
            FN_INSERT:
            begin
                if (held == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // new word lands after every entry <= it
                    pos = 0;
                    while (pos < held && shadow[pos] <= v)
                        pos++;
                    for (k = held; k > pos; k--)
                        shadow[k] = shadow[k-1];
                    shadow[pos] = v;
                    held++;
                end
            end
            FN_READ:
            begin
                if (idx < held)
                    r.data = shadow[idx];
                else
                    r.status = ST_RANGE;
            end
            FN_CLEAR:
                held = 0;
            default:
                ;
        endcase
        r.count = held[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            errs = 0;
            rsp_words = 0;
            replies_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // response first: it belongs to an earlier request word
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                    report("unexpected word, status", '0, 32'(status));
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.status)
                        report("status", 32'(due.status), 32'(status));
                    if (data !== due.data)
                        report("data", due.data, data);
                    if (count !== due.count)
                        report("count", 32'(due.count), 32'(count));
                end
                rsp_words++;
            end
            if (req_valid && !req_stall)
                replies_due.push_back(apply_request(func_t'(func), value, index));
            mismatches  <= errs;
            outstanding <= replies_due.size();
        end
    end

endmodule

### tb/sv/sorted_table_insert_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted table. The checker beside the DUT
// watches both channels and owns all prediction; this module only feeds
// request words, paces the response side and decides pass/fail.
module sorted_table_insert_test;
    import sti_pkg::*;

    localparam int ITEMS        = 600;   // request words to send
    localparam int GAP_MAX      = 17;    // per-word idle/stall draw
    localparam int HOLD_AT      = 120;   // response word that starts the long hold
    localparam int HOLD_OFF     = 300;   // cycles of the long receiver hold
    localparam int IDLE_LIMIT   = 3000;  // watchdog: cycles with no word moving
    localparam int DRAIN_CYCLES = 8;     // spare cycles after the last response

    localparam logic signed [DATA_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] V_MAX = 32'sh7fff_ffff;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    logic [1:0]                func;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
    logic                      rsp_valid;
    logic                      rsp_stall;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  data;
    logic [COUNT_W-1:0]        count;
    int                        mismatches;
    int                        outstanding;

    int                        words_sent;
    int                        words_taken;
    // Burst stretch: both sides run with no gaps while this is set.
    bit                        steady;

    sorted_table_insert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .value     (value),
        .index     (index),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .data      (data),
        .count     (count)
    );

    sorted_table_checker table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .value       (value),
        .index       (index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .data        (data),
        .count       (count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Value mix: extremes, a tight cluster around zero so equal keys are
    // common, and full-range random words for bit coverage.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return int'($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // Any index the field can carry.
    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom_range(0, READ_N - 1));
    endfunction

    // One request word: optional idle gap, then hold it until taken.
    // valid is only lowered when a gap is drawn, so back-to-back words never
    // see a low/high pair of NBAs in the same step.
    task automatic send_word(func_t fn, logic signed [DATA_W-1:0] v,
                             logic [INDEX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= fn;
        value     <= v;
        index     <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        words_sent++;
        // last 40 of every 150 words go gap-free on both sides
        steady = (words_sent % 150) >= 110;
    endtask

    // Receiver: per-word stall draw, plus one long hold so the response
    // register backs up and the DUT has to stall the request side.
    initial
    begin
        int pause;
        rsp_stall   = 1'b0;
        words_taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (words_taken == HOLD_AT)
                pause = HOLD_OFF;
            else
                pause = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (pause > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (pause) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            words_taken++;
        end
    end

    // Watchdog: a run that stops moving words is a failure.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
            if (idle == IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int n;
        int k;
        int r;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        func       = FN_NOP;
        value      = '0;
        index      = '0;
        words_sent = 0;
        steady     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: read of an empty table, extremes and duplicate keys,
        // in-range and out-of-range reads, the spare func code, filling to
        // capacity, insert into a full table, then clear.
        send_word(FN_READ,   '0,     '0);
        send_word(FN_INSERT, 0,      '0);
        send_word(FN_INSERT, V_MAX,  '0);
        send_word(FN_INSERT, V_MIN,  '0);
        send_word(FN_INSERT, 5,      '0);
        send_word(FN_INSERT, 5,      '0);
        send_word(FN_INSERT, -1,     '0);
        send_word(FN_READ,   '0,     4'd0);
        send_word(FN_READ,   '0,     4'd5);
        send_word(FN_READ,   '0,     4'd3);
        send_word(FN_READ,   '0,     4'd15);
        send_word(FN_NOP,    V_MAX,  4'd15);
        for (k = 0; k < 10; k++)
            send_word(FN_INSERT, pick_value(), '0);
        send_word(FN_INSERT, V_MIN,  '0);
        send_word(FN_READ,   '0,     4'd15);
        send_word(FN_CLEAR,  '0,     '0);
        send_word(FN_READ,   '0,     4'd0);

        // Random episodes. Most are clear/fill/scan sequences so the table
        // is driven through every fill level and into overflow; the rest
        // are weighted mixes and raw noise on all fields.
        while (words_sent < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                if ($urandom_range(0, 1))
                    send_word(FN_CLEAR, $urandom, rand_index());
                n = $urandom_range(0, 18);
                repeat (n) send_word(FN_INSERT, pick_value(), rand_index());
                n = $urandom_range(1, 8);
                repeat (n) send_word(FN_READ, $urandom, rand_index());
            end
            else if (kind <= 8)
            begin
                repeat (20)
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        send_word(FN_CLEAR, $urandom, rand_index());
                    else if (r == 1)
                        send_word(FN_NOP, $urandom, rand_index());
                    else if (r <= 10)
                        send_word(FN_INSERT, pick_value(), rand_index());
                    else
                        send_word(FN_READ, $urandom, rand_index());
                end
            end
            else
            begin
                repeat (5)
                    send_word(func_t'($urandom_range(0, 3)), $urandom,
                              rand_index());
            end
        end
        req_valid <= 1'b0;

        // outstanding is updated by NBA, so step one edge before trusting it.
        // The watchdog covers a DUT that never drains.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
